FILE: sv/ajd_pkg.sv
// Shared widths, register codes, reset values and types for the jolt detector.
package ajd_pkg;

  localparam int WORD_W     = 16;
  localparam int COUNT_W    = 14;
  localparam int THR_W      = 14;
  localparam int DEB_W      = 16;
  localparam int NOW_W      = 32;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 16;

  // 0.4 g and 0.55 g at 4096 counts per g, and the default debounce window
  localparam logic [THR_W-1:0] XY_LIMIT_RESET    = 14'd1638;
  localparam logic [THR_W-1:0] Z_LIMIT_RESET     = 14'd2252;
  localparam logic [DEB_W-1:0] DEBOUNCE_MS_RESET = 16'd130;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_XY_LIMIT    = 2'd0,
    REG_Z_LIMIT     = 2'd1,
    REG_DEBOUNCE_MS = 2'd2
  } cfg_reg_t;

  typedef struct packed {
    logic [THR_W-1:0] xy_limit;
    logic [THR_W-1:0] z_limit;
    logic [DEB_W-1:0] debounce_ms;
  } cfg_t;

  typedef logic signed [COUNT_W-1:0] count_t;

endpackage

FILE: sv/axis_jolt_detector.sv
// Top level of the three-axis jolt detector: input register, axis checks, result register.
//
// Sample channel (sample_valid / sample_stall) carries x_word, y_word, z_word
// and now_ms. Each raw word is left-justified; bits 15..2 form a signed count
// at 4096 counts per g. Result channel (result_valid / result_stall) returns
// the three counts and one hit flag per axis for every sample, in order.
// An axis hits when |count - previous count| exceeds its threshold and more
// than debounce_ms has passed (modulo 2^TIME_BITS) since that axis's last hit.
//
// The sample sits in the input register while the per-axis subtract/compare
// settles, and the result register then loads it. Throughput is one sample
// per cycle while result_stall is low; per-axis state updates as a sample
// moves into the result register, so the next sample sees it.
// A stall on the result side holds the result register; the input register
// can still load one more sample, after which sample_stall rises.
// Configuration writes (cfg_valid / cfg_ready, ready always high) belong in
// idle periods. Reset clears both stages, the previous counts and hit times,
// and loads the default thresholds and debounce window.
module axis_jolt_detector #(
  parameter int TIME_BITS = 32
) (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             sample_valid,
  output logic                             sample_stall,
  input  logic [ajd_pkg::WORD_W-1:0]       x_word,
  input  logic [ajd_pkg::WORD_W-1:0]       y_word,
  input  logic [ajd_pkg::WORD_W-1:0]       z_word,
  input  logic [ajd_pkg::NOW_W-1:0]        now_ms,
  output logic                             result_valid,
  input  logic                             result_stall,
  output ajd_pkg::count_t                  x_count,
  output ajd_pkg::count_t                  y_count,
  output ajd_pkg::count_t                  z_count,
  output logic                             hit_x,
  output logic                             hit_y,
  output logic                             hit_z,
  input  logic                             cfg_valid,
  output logic                             cfg_ready,
  input  logic [ajd_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  logic [ajd_pkg::CFG_DATA_W-1:0]   cfg_data
);

  ajd_pkg::cfg_t          cfg;
  logic                   s1_valid;
  ajd_pkg::count_t        s1_x;
  ajd_pkg::count_t        s1_y;
  ajd_pkg::count_t        s1_z;
  logic [TIME_BITS-1:0]   s1_now;
  logic                   out_free;
  logic                   advance;
  logic                   accept;
  logic                   hx;
  logic                   hy;
  logic                   hz;

  ajd_cfg_regs u_cfg (
    .clk       (clk),
    .rst       (rst),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .cfg       (cfg)
  );

  assign out_free     = !result_valid || !result_stall;
  assign advance      = s1_valid && out_free;
  assign sample_stall = s1_valid && !out_free;
  assign accept       = sample_valid && !sample_stall;

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (accept) begin
      s1_valid <= 1'b1;
    end else if (advance) begin
      s1_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      s1_x   <= $signed(x_word[ajd_pkg::WORD_W-1:2]);
      s1_y   <= $signed(y_word[ajd_pkg::WORD_W-1:2]);
      s1_z   <= $signed(z_word[ajd_pkg::WORD_W-1:2]);
      s1_now <= TIME_BITS'(now_ms);
    end
  end

  ajd_axis #(.TIME_BITS(TIME_BITS)) u_axis_x (
    .clk (clk), .rst (rst), .advance (advance), .cur (s1_x), .now (s1_now),
    .threshold (cfg.xy_limit), .debounce_ms (cfg.debounce_ms), .hit (hx)
  );

  ajd_axis #(.TIME_BITS(TIME_BITS)) u_axis_y (
    .clk (clk), .rst (rst), .advance (advance), .cur (s1_y), .now (s1_now),
    .threshold (cfg.xy_limit), .debounce_ms (cfg.debounce_ms), .hit (hy)
  );

  ajd_axis #(.TIME_BITS(TIME_BITS)) u_axis_z (
    .clk (clk), .rst (rst), .advance (advance), .cur (s1_z), .now (s1_now),
    .threshold (cfg.z_limit), .debounce_ms (cfg.debounce_ms), .hit (hz)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      result_valid <= 1'b0;
    end else if (advance) begin
      result_valid <= 1'b1;
    end else if (out_free) begin
      result_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      x_count <= s1_x;
      y_count <= s1_y;
      z_count <= s1_z;
      hit_x   <= hx;
      hit_y   <= hy;
      hit_z   <= hz;
    end
  end

  a_result_from_stage: assert property (@(posedge clk) disable iff (rst)
    $rose(result_valid) |-> $past(s1_valid))
    else $error("result appeared without a staged sample");

  a_drain_empties: assert property (@(posedge clk) disable iff (rst)
    result_valid && !result_stall && !s1_valid |=> !result_valid)
    else $error("result repeated after transaction");

  a_stage_moves: assert property (@(posedge clk) disable iff (rst)
    s1_valid && out_free |=> result_valid && x_count == $past(s1_x))
    else $error("staged sample did not reach result register");

endmodule

FILE: sv/ajd_cfg_regs.sv
// Configuration register file: thresholds and debounce window.
module ajd_cfg_regs (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             cfg_valid,
  output logic                             cfg_ready,
  input  logic [ajd_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  logic [ajd_pkg::CFG_DATA_W-1:0]   cfg_data,
  output ajd_pkg::cfg_t                    cfg
);

  logic write;

  assign cfg_ready = 1'b1;
  assign write     = cfg_valid && cfg_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.xy_limit    <= ajd_pkg::XY_LIMIT_RESET;
      cfg.z_limit     <= ajd_pkg::Z_LIMIT_RESET;
      cfg.debounce_ms <= ajd_pkg::DEBOUNCE_MS_RESET;
    end else if (write) begin
      // unknown indexes are dropped; wide data keeps its low bits
      unique case (ajd_pkg::cfg_reg_t'(cfg_index))
        ajd_pkg::REG_XY_LIMIT: begin
          cfg.xy_limit <= cfg_data[ajd_pkg::THR_W-1:0];
        end
        ajd_pkg::REG_Z_LIMIT: begin
          cfg.z_limit <= cfg_data[ajd_pkg::THR_W-1:0];
        end
        ajd_pkg::REG_DEBOUNCE_MS: begin
          cfg.debounce_ms <= cfg_data[ajd_pkg::DEB_W-1:0];
        end
        default: begin
        end
      endcase
    end
  end

endmodule

FILE: sv/ajd_axis.sv
// One axis: previous count, last hit time, delta threshold and debounce check.
module ajd_axis #(
  parameter int TIME_BITS = 32
) (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         advance,
  input  ajd_pkg::count_t              cur,
  input  logic [TIME_BITS-1:0]         now,
  input  logic [ajd_pkg::THR_W-1:0]    threshold,
  input  logic [ajd_pkg::DEB_W-1:0]    debounce_ms,
  output logic                         hit
);

  ajd_pkg::count_t                    last;
  logic [TIME_BITS-1:0]               hit_time;
  logic [TIME_BITS-1:0]               elapsed;
  logic signed [ajd_pkg::COUNT_W:0]   delta;
  logic signed [ajd_pkg::COUNT_W:0]   delta_neg;
  logic [ajd_pkg::COUNT_W-1:0]        abs_delta;

  always_comb begin
    delta     = $signed({cur[ajd_pkg::COUNT_W-1], cur}) -
                $signed({last[ajd_pkg::COUNT_W-1], last});
    delta_neg = -delta;
    // |delta| tops out at 16383, so it fits the count width unsigned
    abs_delta = delta[ajd_pkg::COUNT_W] ? delta_neg[ajd_pkg::COUNT_W-1:0]
                                        : delta[ajd_pkg::COUNT_W-1:0];
    elapsed   = now - hit_time;   // modular, handles timestamp wrap
    hit       = (abs_delta > threshold) && (elapsed > TIME_BITS'(debounce_ms));
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      last     <= '0;
      hit_time <= '0;
    end else if (advance) begin
      last <= cur;
      if (hit) begin
        hit_time <= now;
      end
    end
  end

  a_hit_records_time: assert property (@(posedge clk) disable iff (rst)
    advance && hit |=> hit_time == $past(now))
    else $error("hit time not recorded");

  a_no_hit_keeps_time: assert property (@(posedge clk) disable iff (rst)
    !(advance && hit) |=> $stable(hit_time))
    else $error("hit time changed without a hit");

endmodule
